// ===== src/eit_pkg.sv =====
// Package with the constants, codes and types shared by the expiring id table.
package eit_pkg;

    // Table geometry and limits.
    localparam int TABLE_DEPTH = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    // Field widths of the channel payloads.
    localparam int KIND_W   = 2;
    localparam int ID_W     = 32;
    localparam int TMO_W    = 31;
    localparam int TIME_W   = 48;
    localparam int REASON_W = 2;
    localparam int EVENT_W  = 2;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    // Result events.
    localparam logic [EVENT_W-1:0] EV_ADDED    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_REPLACED = 2'd1;
    localparam logic [EVENT_W-1:0] EV_CLOSED   = 2'd2;
    localparam logic [EVENT_W-1:0] EV_FULL     = 2'd3;

    // Close reasons; add events report the expired code as a neutral value.
    localparam logic [REASON_W-1:0] RSN_EXPIRED = 2'd0;
    localparam logic [REASON_W-1:0] RSN_NONE    = 2'd0;

    // One table entry as held in the memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    // One result waiting for its last flag.
    typedef struct packed {
        logic [EVENT_W-1:0]  ev;
        logic [ID_W-1:0]     id;
        logic [REASON_W-1:0] rsn;
    } t_result;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

// ===== src/eit_in_if.sv =====
// Input channel interface of the expiring id table.
interface eit_in_if;
    logic                          valid;
    logic                          ready;
    logic [eit_pkg::KIND_W-1:0]    kind;
    logic [eit_pkg::ID_W-1:0]      note_id;
    logic [eit_pkg::TMO_W-1:0]     timeout_ms;
    logic [eit_pkg::TIME_W-1:0]    now_ms;
    logic [eit_pkg::REASON_W-1:0]  close_reason;

    modport source (
        output valid, kind, note_id, timeout_ms, now_ms, close_reason,
        input  ready
    );
    modport sink (
        input  valid, kind, note_id, timeout_ms, now_ms, close_reason,
        output ready
    );
endinterface

// ===== src/eit_out_if.sv =====
// Result channel interface of the expiring id table.
interface eit_out_if;
    logic                          valid;
    logic                          ready;
    logic [eit_pkg::EVENT_W-1:0]   event_res;
    logic [eit_pkg::ID_W-1:0]      entry_id;
    logic [eit_pkg::REASON_W-1:0]  reason;
    logic                          last;

    modport source (
        output valid, event_res, entry_id, reason, last,
        input  ready
    );
    modport sink (
        input  valid, event_res, entry_id, reason, last,
        output ready
    );
endinterface

// ===== src/expiring_id_table.sv =====
// Expiring id table: ordered id/expiry table in a memory, scanned one slot per cycle
// unless a new result meets a held pending result and an unaccepted output beat. Items are
// taken one at a time: the next is accepted only once the last result of the previous one
// is in the output register. Synchronous active-low reset empties the table and clears the
// sequencer and channel state at once; the memory contents are left and never read unwritten.
module expiring_id_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    eit_in_if.sink         i_in,
    eit_out_if.source      o_out
);
    import eit_pkg::*;

    // Table memory and its registered read port.
    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd_data;

    // Sequencer and scan state.
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [CNT_W-1:0]     r_ri, n_ri;
    logic [CNT_W-1:0]     r_wr, n_wr;
    logic                 r_dv, n_dv;
    logic                 r_found, n_found;
    logic [RES_CNT_W-1:0] r_n, n_n;

    // Captured item.
    logic [KIND_W-1:0]    r_kind;
    logic [ID_W-1:0]      r_id;
    logic [TIME_W-1:0]    r_now;
    logic [REASON_W-1:0]  r_rsn;
    logic [TIME_W-1:0]    r_exp;
    logic [TIME_W-1:0]    in_exp;
    logic [TIME_W:0]      exp_sum;

    // Pending result and output register.
    t_result              r_pend, n_pend;
    logic                 r_pend_vld, n_pend_vld;
    t_result              r_out, n_out;
    logic                 r_out_last, n_out_last;
    logic                 r_out_vld, n_out_vld;

    // Memory port controls.
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    t_entry               wr_data;
    logic [CNT_W-1:0]     cur_idx;

    // Decisions on the slot currently read out.
    logic                 in_acc;
    logic                 out_free;
    logic                 hit_add;
    logic                 hit_close;
    logic                 hit_tick;
    logic                 do_remove;
    logic                 res_new;
    logic                 stall;
    logic                 scan_done;

    assign in_acc     = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);
    assign out_free   = !r_out_vld || o_out.ready;

    assign o_out.valid     = r_out_vld;
    assign o_out.event_res = r_out.ev;
    assign o_out.entry_id  = r_out.id;
    assign o_out.reason    = r_out.rsn;
    assign o_out.last      = r_out_last;

    // Absolute expiry of an add, zero for a zero timeout, saturating at the top of the time range.
    assign exp_sum = {1'b0, i_in.now_ms} + (TIME_W + 1)'(i_in.timeout_ms);
    always_comb begin
        if (i_in.timeout_ms == '0) begin
            in_exp = '0;
        end else if (exp_sum[TIME_W]) begin
            in_exp = '1;
        end else begin
            in_exp = exp_sum[TIME_W-1:0];
        end
    end

    // Classification of the slot whose data has just come out of the memory.
    assign hit_add   = (r_state == ST_SCAN) && r_dv && (r_kind == KIND_ADD)
                       && (r_id != '0) && (r_rd_data.id == r_id);
    assign hit_close = (r_state == ST_SCAN) && r_dv && (r_kind == KIND_CLOSE)
                       && !r_found && (r_rd_data.id == r_id);
    assign hit_tick  = (r_state == ST_SCAN) && r_dv && (r_kind == KIND_TICK)
                       && (r_rd_data.expiry != '0) && (r_rd_data.expiry <= r_now)
                       && (r_n < RES_CNT_W'(MAX_RESULTS));
    assign do_remove = hit_close || hit_tick;
    assign res_new   = hit_add || do_remove;
    assign stall     = res_new && r_pend_vld && !out_free;
    assign scan_done = (r_state == ST_SCAN) && !r_dv && (r_ri == r_cnt);
    assign cur_idx   = r_ri - CNT_W'(1);
    assign rd_addr   = r_ri[IDX_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == KIND_ADD || i_in.kind == KIND_CLOSE
                        || i_in.kind == KIND_TICK) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_SCAN: begin
                if (hit_add || scan_done) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!r_pend_vld || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Scan datapath, memory controls and result registers.
    always_comb begin
        n_cnt      = r_cnt;
        n_ri       = r_ri;
        n_wr       = r_wr;
        n_dv       = r_dv;
        n_found    = r_found;
        n_n        = r_n;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out      = r_out;
        n_out_last = r_out_last;
        n_out_vld  = r_out_vld;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_wr[IDX_W-1:0];
        wr_data    = r_rd_data;

        if (o_out.ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                n_ri    = '0;
                n_wr    = '0;
                n_dv    = 1'b0;
                n_found = 1'b0;
                n_n     = '0;
            end
            ST_SCAN: begin
                if (!stall) begin
                    rd_en = (r_ri < r_cnt) && !hit_add;
                    n_ri  = r_ri + CNT_W'(rd_en);
                    n_dv  = rd_en;

                    // A new result pushes the previous one out as a non-final beat.
                    if (res_new && r_pend_vld) begin
                        n_out      = r_pend;
                        n_out_last = 1'b0;
                        n_out_vld  = 1'b1;
                    end

                    if (hit_add) begin
                        // Replace the expiry in place.
                        wr_en      = 1'b1;
                        wr_addr    = cur_idx[IDX_W-1:0];
                        wr_data    = '{id: r_id, expiry: r_exp};
                        n_pend     = '{ev: EV_REPLACED, id: r_id, rsn: RSN_NONE};
                        n_pend_vld = 1'b1;
                    end else if (do_remove) begin
                        n_pend.ev  = EV_CLOSED;
                        n_pend.id  = r_rd_data.id;
                        n_pend.rsn = hit_close ? r_rsn : RSN_EXPIRED;
                        n_pend_vld = 1'b1;
                        n_found    = 1'b1;
                        n_n        = r_n + RES_CNT_W'(1);
                    end else if (r_dv && (r_kind != KIND_ADD)) begin
                        // Kept entry is compacted down to the write pointer.
                        wr_en = 1'b1;
                        n_wr  = r_wr + CNT_W'(1);
                    end
                end

                // End of scan: append an unmatched add if there is room (else report full), else take the kept count.
                if (scan_done) begin
                    if (r_kind == KIND_ADD) begin
                        n_pend_vld = 1'b1;
                        if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                            wr_en   = 1'b1;
                            wr_addr = r_cnt[IDX_W-1:0];
                            wr_data = '{id: r_id, expiry: r_exp};
                            n_cnt   = r_cnt + CNT_W'(1);
                            n_pend  = '{ev: EV_ADDED, id: r_id, rsn: RSN_NONE};
                        end else begin
                            n_pend  = '{ev: EV_FULL, id: r_id, rsn: RSN_NONE};
                        end
                    end else begin
                        n_cnt = r_wr;
                    end
                end
            end
            ST_FLUSH: begin
                n_dv = 1'b0;
                if (r_pend_vld && out_free) begin
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_out_vld  = 1'b1;
                    n_pend_vld = 1'b0;
                end
            end
            default: begin
                n_dv = 1'b0;
            end
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cnt      <= '0;
            r_dv       <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_ri       <= '0;
            r_wr       <= '0;
            r_found    <= 1'b0;
            r_n        <= '0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_dv       <= n_dv;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            r_ri       <= n_ri;
            r_wr       <= n_wr;
            r_found    <= n_found;
            r_n        <= n_n;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
        if (in_acc) begin
            r_kind <= i_in.kind;
            r_id   <= i_in.note_id;
            r_now  <= i_in.now_ms;
            r_rsn  <= i_in.close_reason;
            r_exp  <= in_exp;
        end
    end

endmodule

// ===== test/expiring_id_table_tb.sv =====
// Self-checking testbench for the expiring id table: directed table, then random items.
`timescale 1ns / 100ps

module expiring_id_table_tb;
    import eit_pkg::*;

    // Kind code that the block ignores.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Close reasons passed through on a close by id.
    localparam logic [REASON_W-1:0] RSN_DISMISSED = 2'd1;
    localparam logic [REASON_W-1:0] RSN_REQUEST   = 2'd2;
    localparam logic [REASON_W-1:0] RSN_UNDEFINED = 2'd3;

    localparam int RESET_CYCLES  = 11;
    localparam int RANDOM_ITEMS  = 235;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_AT_ITEM  = 90;
    localparam int DRAIN_AT_ITEM = 180;
    localparam int LONG_HOLD     = 400;
    // Long enough to cover an item still in work.
    localparam int SETTLE_CYCLES = 40;
    // Worst case is about 300 items of 16 beats, each beat stalled; taken several times.
    localparam int LIMIT_CYCLES  = 1500000;
    localparam int MAX_REPORTS   = 10;

    // One input item as offered on the input channel.
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [ID_W-1:0]     note_id;
        logic [TMO_W-1:0]    timeout_ms;
        logic [TIME_W-1:0]   now_ms;
        logic [REASON_W-1:0] close_reason;
    } t_item;

    // One result beat as it should appear on the result channel.
    typedef struct packed {
        logic [EVENT_W-1:0]  ev;
        logic [ID_W-1:0]     id;
        logic [REASON_W-1:0] rsn;
        logic                last;
    } t_beat;

    // How a directed row is checked: by the table model, no beat, or one typed beat.
    typedef enum {CHK_MODEL, CHK_NONE, CHK_ONE} t_chk;

    typedef struct {
        t_item it;
        int    reps;
        t_chk  chk;
        t_beat typed;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    eit_in_if  in_ch ();
    eit_out_if out_ch ();

    expiring_id_table DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #6 i_clk = ~i_clk;

    // Table model state: entries packed at the low slots in arrival order.
    logic [ID_W-1:0]   tbl_id  [TABLE_DEPTH];
    logic [TIME_W-1:0] tbl_exp [TABLE_DEPTH];
    int                tbl_count;

    t_beat step_beats[$];
    t_beat pending_beats[$];
    t_row  script[$];

    int   mismatches   = 0;
    int   cycles       = 0;
    logic hold_off_req = 1'b0;
    t_beat want;

    function automatic t_beat make_beat(input logic [EVENT_W-1:0] ev,
                                        input logic [ID_W-1:0] id,
                                        input logic [REASON_W-1:0] rsn);
        t_beat b;
        b.ev   = ev;
        b.id   = id;
        b.rsn  = rsn;
        b.last = 1'b0;
        return b;
    endfunction

    // Removing an entry shifts the later ones down by one place.
    function automatic void drop_slot(input int pos);
        int j;
        for (j = pos; j + 1 < tbl_count; j++) begin
            tbl_id[j]  = tbl_id[j + 1];
            tbl_exp[j] = tbl_exp[j + 1];
        end
        tbl_count--;
    endfunction

    // Applies one item to the table model and leaves its beats in step_beats.
    function automatic void table_apply(input t_item it);
        logic [TIME_W:0]   sum;
        logic [TIME_W-1:0] expiry;
        int                i;
        int                hit;
        int                n;
        step_beats.delete();
        case (it.kind)
            KIND_ADD: begin
                sum = {1'b0, it.now_ms} + {{(TIME_W + 1 - TMO_W){1'b0}}, it.timeout_ms};
                if (it.timeout_ms == '0)
                    expiry = '0;
                else if (sum[TIME_W])
                    expiry = '1;
                else
                    expiry = sum[TIME_W-1:0];
                hit = -1;
                // Id zero never replaces an entry.
                if (it.note_id != '0) begin
                    for (i = 0; i < tbl_count; i++) begin
                        if (tbl_id[i] == it.note_id) begin
                            hit = i;
                            break;
                        end
                    end
                end
                if (hit >= 0) begin
                    tbl_exp[hit] = expiry;
                    step_beats.push_back(make_beat(EV_REPLACED, it.note_id, RSN_NONE));
                end else if (tbl_count < TABLE_DEPTH) begin
                    tbl_id[tbl_count]  = it.note_id;
                    tbl_exp[tbl_count] = expiry;
                    tbl_count++;
                    step_beats.push_back(make_beat(EV_ADDED, it.note_id, RSN_NONE));
                end else begin
                    step_beats.push_back(make_beat(EV_FULL, it.note_id, RSN_NONE));
                end
            end
            KIND_CLOSE: begin
                for (i = 0; i < tbl_count; i++) begin
                    if (tbl_id[i] == it.note_id) begin
                        drop_slot(i);
                        step_beats.push_back(make_beat(EV_CLOSED, it.note_id,
                                                       it.close_reason));
                        break;
                    end
                end
            end
            KIND_TICK: begin
                // Expired entries go in table order, at most MAX_RESULTS per tick.
                i = 0;
                n = 0;
                while (i < tbl_count && n < MAX_RESULTS) begin
                    if (tbl_exp[i] != '0 && tbl_exp[i] <= it.now_ms) begin
                        step_beats.push_back(make_beat(EV_CLOSED, tbl_id[i], RSN_EXPIRED));
                        n++;
                        drop_slot(i);
                    end else begin
                        i++;
                    end
                end
            end
            default: ;
        endcase
        if (step_beats.size() > 0)
            step_beats[step_beats.size() - 1].last = 1'b1;
    endfunction

    function automatic t_row row(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                                 input logic [TMO_W-1:0] tmo, input logic [TIME_W-1:0] now,
                                 input logic [REASON_W-1:0] rsn, input int reps,
                                 input t_chk chk, input logic [EVENT_W-1:0] ev,
                                 input logic [ID_W-1:0] rid,
                                 input logic [REASON_W-1:0] rrsn);
        t_row r;
        r.it.kind         = kind;
        r.it.note_id      = id;
        r.it.timeout_ms   = tmo;
        r.it.now_ms       = now;
        r.it.close_reason = rsn;
        r.reps            = reps;
        r.chk             = chk;
        r.typed           = make_beat(ev, rid, rrsn);
        r.typed.last      = 1'b1;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    // Ids mostly come from a small pool so that replaces and closes hit.
    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(0, 3) != 0)
            return ID_W'($urandom_range(0, 23));
        else
            return ID_W'($urandom);
    endfunction

    function automatic logic [TMO_W-1:0] pick_timeout();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return '0;
        else if (r < 75)
            return TMO_W'($urandom_range(1, 40));
        else if (r < 90)
            return TMO_W'($urandom_range(1, 2000));
        else
            return TMO_W'($urandom);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // Offers one item, then returns at the edge where it is accepted.
    task automatic offer_item(input t_item it, input int gap);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.kind         <= it.kind;
        in_ch.note_id      <= it.note_id;
        in_ch.timeout_ms   <= it.timeout_ms;
        in_ch.now_ms       <= it.now_ms;
        in_ch.close_reason <= it.close_reason;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Stops offering until every expected beat has arrived and the block has settled.
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: runs of ready, random gaps, and one long hold-off on request.
    initial begin : result_sink
        int  high_left;
        int  low_left;
        logic rdy;
        high_left    = 0;
        low_left     = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                high_left    = 0;
                low_left     = LONG_HOLD;
            end
            if (low_left > 0) begin
                low_left--;
                rdy = 1'b0;
            end else begin
                if (high_left == 0)
                    high_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 24);
                high_left--;
                rdy = 1'b1;
                if (high_left == 0)
                    low_left = pick_gap();
            end
            out_ch.ready <= rdy;
        end
    end

    // Each accepted result beat is checked against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_beats.size() == 0) begin
                report($sformatf("unexpected beat: ev=%0d id=%0h rsn=%0d last=%0b",
                                 out_ch.event_res, out_ch.entry_id, out_ch.reason,
                                 out_ch.last));
            end else begin
                want = pending_beats.pop_front();
                if (out_ch.event_res !== want.ev || out_ch.entry_id !== want.id ||
                    out_ch.reason !== want.rsn || out_ch.last !== want.last)
                    report($sformatf({"beat mismatch: expected ev=%0d id=%0h rsn=%0d ",
                                      "last=%0b, got ev=%0d id=%0h rsn=%0d last=%0b"},
                                     want.ev, want.id, want.rsn, want.last,
                                     out_ch.event_res, out_ch.entry_id, out_ch.reason,
                                     out_ch.last));
            end
        end
    end

    // Run limit.
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        t_item            item;
        int               k;
        int               serial;
        int               counted;
        int               r;
        logic             no_idle;
        logic [TIME_W-1:0] tbase;

        i_rst_n            = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.kind         = KIND_ADD;
        in_ch.note_id      = '0;
        in_ch.timeout_ms   = '0;
        in_ch.now_ms       = '0;
        in_ch.close_reason = RSN_EXPIRED;
        tbl_count          = 0;

        // Directed rows: empty table, extremes, id zero, replace, full table, mass expiry.
        script.push_back(row(KIND_TICK, 0, 0, 0, RSN_EXPIRED, 1, CHK_NONE, 0, 0, 0));
        script.push_back(row(KIND_CLOSE, 5, 0, 0, RSN_DISMISSED, 1, CHK_NONE, 0, 0, 0));
        script.push_back(row(KIND_UNUSED, '1, '1, '1, '1, 1, CHK_NONE, 0, 0, 0));
        script.push_back(row(KIND_ADD, '1, '1, '1, RSN_EXPIRED, 1,
                             CHK_ONE, EV_ADDED, '1, RSN_NONE));
        script.push_back(row(KIND_ADD, 0, 0, 0, RSN_REQUEST, 1,
                             CHK_ONE, EV_ADDED, 0, RSN_NONE));
        script.push_back(row(KIND_ADD, 0, 10, 0, RSN_EXPIRED, 1,
                             CHK_ONE, EV_ADDED, 0, RSN_NONE));
        script.push_back(row(KIND_ADD, '1, 100, 1000, RSN_EXPIRED, 1,
                             CHK_ONE, EV_REPLACED, '1, RSN_NONE));
        script.push_back(row(KIND_CLOSE, 0, 0, 0, RSN_UNDEFINED, 1,
                             CHK_ONE, EV_CLOSED, 0, RSN_UNDEFINED));
        script.push_back(row(KIND_TICK, 0, 0, 10, RSN_EXPIRED, 1,
                             CHK_ONE, EV_CLOSED, 0, RSN_EXPIRED));
        script.push_back(row(KIND_TICK, 0, 0, 1100, RSN_EXPIRED, 1,
                             CHK_ONE, EV_CLOSED, '1, RSN_EXPIRED));
        script.push_back(row(KIND_ADD, 32'h100, 5, 2000, RSN_EXPIRED, 16,
                             CHK_MODEL, 0, 0, 0));
        script.push_back(row(KIND_ADD, 32'h200, 5, 2000, RSN_EXPIRED, 1,
                             CHK_ONE, EV_FULL, 32'h200, RSN_NONE));
        script.push_back(row(KIND_ADD, 32'h10F, 7, 2000, RSN_EXPIRED, 1,
                             CHK_ONE, EV_REPLACED, 32'h10F, RSN_NONE));
        script.push_back(row(KIND_CLOSE, 32'h103, 0, 0, RSN_DISMISSED, 1,
                             CHK_ONE, EV_CLOSED, 32'h103, RSN_DISMISSED));
        script.push_back(row(KIND_CLOSE, 32'h104, 0, 0, RSN_REQUEST, 1,
                             CHK_ONE, EV_CLOSED, 32'h104, RSN_REQUEST));
        script.push_back(row(KIND_ADD, 32'h300, 7, 2000, RSN_EXPIRED, 2,
                             CHK_MODEL, 0, 0, 0));
        script.push_back(row(KIND_TICK, 0, 0, 2007, RSN_EXPIRED, 1, CHK_MODEL, 0, 0, 0));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part.
        foreach (script[ri]) begin
            for (k = 0; k < script[ri].reps; k++) begin
                item         = script[ri].it;
                item.note_id = item.note_id + ID_W'(k);
                offer_item(item, pick_gap());
                table_apply(item);
                case (script[ri].chk)
                    CHK_MODEL: foreach (step_beats[bi]) pending_beats.push_back(step_beats[bi]);
                    CHK_ONE:   pending_beats.push_back(script[ri].typed);
                    default:   ;
                endcase
            end
        end

        // Random part in phases, each with its own time base and idling style.
        serial  = 0;
        counted = 0;
        tbase   = '0;
        no_idle = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            if (serial % PHASE_ITEMS == 0) begin
                r = $urandom_range(0, 3);
                if (r == 0)
                    tbase = TIME_W'($urandom_range(0, 100));
                else if (r == 1)
                    tbase = '1 - TIME_W'($urandom_range(0, 4000));
                else
                    tbase = {16'($urandom), 32'($urandom)};
                no_idle = ($urandom_range(0, 3) == 0);
            end
            // The result side holds off while items keep coming.
            if (serial == HOLD_AT_ITEM)
                hold_off_req = 1'b1;
            if (serial == DRAIN_AT_ITEM)
                wait_drained();

            r = $urandom_range(0, 99);
            if (r < 45)
                item.kind = KIND_ADD;
            else if (r < 67)
                item.kind = KIND_CLOSE;
            else if (r < 95)
                item.kind = KIND_TICK;
            else
                item.kind = KIND_UNUSED;
            item.note_id      = pick_id();
            item.timeout_ms   = pick_timeout();
            item.now_ms       = tbase;
            item.close_reason = REASON_W'($urandom_range(0, 3));
            tbase             = tbase + TIME_W'($urandom_range(0, 8));

            offer_item(item, no_idle ? 0 : pick_gap());
            table_apply(item);
            foreach (step_beats[bi]) pending_beats.push_back(step_beats[bi]);
            if (item.kind != KIND_UNUSED)
                counted++;
            serial++;
        end

        wait_drained();
        if (mismatches == 0 && pending_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
